[src/ntlrb_pkg.sv]
`default_nettype none
package ntlrb_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int SERVER_COUNT = 4;
    localparam int STAMP_W = 48;
    localparam int LOAD_W = 31;

    localparam logic [1:0] V_PASS = 2'd0;
    localparam logic [1:0] V_REWRITE = 2'd1;
    localparam logic [1:0] V_DROP = 2'd2;

    localparam logic [2:0] CFG_PUBLIC_ADDR = 3'd0;
    localparam logic [2:0] CFG_PUBLIC_PORT = 3'd1;
    localparam logic [2:0] CFG_SERVER_0 = 3'd2;
    localparam logic [2:0] CFG_SERVER_3 = 3'd5;

    // one table row
    typedef struct packed {
        logic [31:0]        ip;
        logic [15:0]        port;
        logic [1:0]         server;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // word handed down the chain during a search
    typedef struct packed {
        logic [31:0]        ip;
        logic [15:0]        port;
        logic               hit;
        logic [IDX_W-1:0]   hit_slot;
        logic [STAMP_W-1:0] old_stamp;
        logic [IDX_W-1:0]   old_slot;
    } probe_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   slot;
        logic               fill;
        entry_t             data;
    } wr_t;
endpackage
`default_nettype wire

[src/ntlrb_cell.sv]
`default_nettype none
module ntlrb_cell
    import ntlrb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] my_slot,
    input  wire logic [CNT_W-1:0] entry_count,
    input  wire wr_t              wr,
    input  wire probe_t           probe_in,
    output      probe_t           probe_out,
    output      logic [1:0]       server
);
    entry_t entry_reg;
    logic   live;

    always_ff @(posedge clk)
    begin
        if (wr.we && wr.slot == my_slot)
        begin
            if (wr.fill)
                entry_reg <= wr.data;
            else
                entry_reg.stamp <= wr.data.stamp;
        end
    end

    assign live = {1'b0, my_slot} < entry_count;
    assign server = entry_reg.server;

    always_comb
    begin
        probe_out = probe_in;
        if (!probe_in.hit && live && entry_reg.ip == probe_in.ip
            && entry_reg.port == probe_in.port)
        begin
            probe_out.hit = 1'b1;
            probe_out.hit_slot = my_slot;
        end
        if (my_slot == '0 || entry_reg.stamp < probe_in.old_stamp)
        begin
            probe_out.old_stamp = entry_reg.stamp;
            probe_out.old_slot = my_slot;
        end
    end
endmodule
`default_nettype wire

[src/ntlrb_chain.sv]
`default_nettype none
module ntlrb_chain
    import ntlrb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [31:0]      key_ip,
    input  wire logic [15:0]      key_port,
    input  wire logic [CNT_W-1:0] entry_count,
    input  wire wr_t              wr,
    output      probe_t           result,
    output      logic             done,
    input  wire logic [IDX_W-1:0] rd_slot,
    output      logic [1:0]       rd_server
);
    // cells are evaluated in groups of four per cycle: a registered probe word
    // walks down the row
    localparam int GRP = 4;
    localparam int NGRP = (TABLE_DEPTH + GRP - 1) / GRP;
    localparam int GW = (NGRP > 1) ? $clog2(NGRP + 1) : 1;

    probe_t             chain [TABLE_DEPTH+1];
    probe_t             seed;
    logic [1:0]         srv [TABLE_DEPTH];
    probe_t             probe_reg, probe_next;
    logic [GW-1:0]      grp_reg;
    logic               busy_reg;

    always_comb
    begin
        seed = '0;
        seed.ip = key_ip;
        seed.port = key_port;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            probe_t pin;
            assign pin = (g % GRP == 0) ? probe_reg : chain[g];
            ntlrb_cell u_cell (
                .clk        (clk),
                .my_slot    (IDX_W'(g)),
                .entry_count(entry_count),
                .wr         (wr),
                .probe_in   (pin),
                .probe_out  (chain[g+1]),
                .server     (srv[g])
            );
        end
    endgenerate
    assign chain[0] = probe_reg;

    always_comb
    begin
        probe_next = probe_reg;
        for (int k = 0; k < NGRP; k++)
            if (grp_reg == GW'(k))
                probe_next = chain[(k*GRP+GRP > TABLE_DEPTH) ? TABLE_DEPTH : k*GRP+GRP];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg <= '0;
            probe_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            grp_reg <= '0;
            probe_reg <= seed;
        end
        else if (busy_reg)
        begin
            probe_reg <= probe_next;
            grp_reg <= grp_reg + 1'b1;
            if (grp_reg == GW'(NGRP - 1))
                busy_reg <= 1'b0;
        end
    end

    assign done = busy_reg && grp_reg == GW'(NGRP - 1);
    assign result = probe_next;
    assign rd_server = srv[rd_slot];
endmodule
`default_nettype wire

[src/nat_table_least_rate_balancer_core.sv]
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | action is_udp src_ip dst_ip src_port dst_port
// out     | out_valid | out_ready | verdict out_src_ip out_dst_ip server_index new_entry
// cfg     | cfg_valid | cfg_ready | cfg_index cfg_data
// A word goes through these steps: accept, 4 search steps over the cell row (four cells a
// step), an update step; the result then sits in the output register.
// A new word is taken while the result waits, but work stalls on a full output register.
// Reset clears the fill count, tick counter and server counters; table rows
// hold whatever they last held and are only read below the fill count.
`default_nettype none
module nat_table_least_rate_balancer_core
    import ntlrb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic        action,
    input  wire logic        is_udp,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [1:0]  verdict,
    output      logic [31:0] out_src_ip,
    output      logic [31:0] out_dst_ip,
    output      logic [1:0]  server_index,
    output      logic        new_entry,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]         state_reg;
    logic [31:0]        pub_addr_reg;
    logic [15:0]        pub_port_reg;
    logic [31:0]        srv_addr_reg [SERVER_COUNT];
    logic [CNT_W-1:0]   count_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [LOAD_W-1:0]  load_reg [SERVER_COUNT];
    logic               act_reg, udp_reg;
    logic [31:0]        sip_reg, dip_reg;
    logic [15:0]        sport_reg, dport_reg;
    probe_t             res, res_reg;
    logic               done, start;
    wr_t                wr;
    logic [IDX_W-1:0]   rd_slot;
    logic [1:0]         rd_server, least;
    logic               inb, lookup_ok;

    logic        ov_reg;
    logic [1:0]  v_reg, si_reg;
    logic [31:0] os_reg, od_reg;
    logic        ne_reg;

    assign in_ready = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign start = in_valid && in_ready;
    assign inb = !act_reg;
    assign lookup_ok = inb ? (dip_reg != 32'd0 && dip_reg == pub_addr_reg
                              && dport_reg == pub_port_reg) : 1'b1;

    ntlrb_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .key_ip     (action ? dst_ip : src_ip),
        .key_port   (action ? dst_port : src_port),
        .entry_count(count_reg),
        .wr         (wr),
        .result     (res),
        .done       (done),
        .rd_slot    (rd_slot),
        .rd_server  (rd_server)
    );

    always_comb
    begin
        least = 2'd0;
        for (int i = 1; i < SERVER_COUNT; i++)
            if (load_reg[i] < load_reg[least])
                least = 2'(i);
    end

    logic             miss_ins;
    logic [IDX_W-1:0] ins_slot;
    logic             do_upd;
    logic [1:0]       sidx;

    assign do_upd = state_reg == S_UPD && !ov_reg && udp_reg && lookup_ok
                    && (inb || res_reg.hit);
    assign miss_ins = inb && !res_reg.hit;
    assign ins_slot = (count_reg >= CNT_W'(TABLE_DEPTH)) ? res_reg.old_slot
                                                         : count_reg[IDX_W-1:0];
    assign rd_slot = res_reg.hit_slot;
    assign sidx = miss_ins ? least : rd_server;

    always_comb
    begin
        wr.we = do_upd;
        wr.slot = miss_ins ? ins_slot : res_reg.hit_slot;
        wr.fill = miss_ins;
        wr.data.ip = sip_reg;
        wr.data.port = sport_reg;
        wr.data.server = least;
        wr.data.stamp = clock_reg;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            act_reg <= action;
            udp_reg <= is_udp;
            sip_reg <= src_ip;
            dip_reg <= dst_ip;
            sport_reg <= src_port;
            dport_reg <= dst_port;
        end
        if (done)
            res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pub_addr_reg <= 32'd2560099736;
            pub_port_reg <= 16'd36895;
            srv_addr_reg[0] <= 32'd16885952;
            srv_addr_reg[1] <= 32'd16951488;
            srv_addr_reg[2] <= 32'd17017024;
            srv_addr_reg[3] <= 32'd17082560;
            count_reg <= '0;
            clock_reg <= '0;
            for (int i = 0; i < SERVER_COUNT; i++)
                load_reg[i] <= '0;
            ov_reg <= 1'b0;
            v_reg <= V_PASS;
            os_reg <= '0;
            od_reg <= '0;
            si_reg <= 2'd0;
            ne_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_PUBLIC_ADDR)
                    pub_addr_reg <= cfg_data;
                else if (cfg_index == CFG_PUBLIC_PORT)
                    pub_port_reg <= cfg_data[15:0];
                else if (cfg_index >= CFG_SERVER_0 && cfg_index <= CFG_SERVER_3)
                    srv_addr_reg[2'(cfg_index - CFG_SERVER_0)] <= cfg_data;
            end
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_SRCH;
                end
                S_SRCH:
                begin
                    if (done)
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (!ov_reg)
                    begin
                        state_reg <= S_IDLE;
                        ov_reg <= 1'b1;
                        v_reg <= V_PASS;
                        os_reg <= sip_reg;
                        od_reg <= dip_reg;
                        si_reg <= 2'd0;
                        ne_reg <= 1'b0;
                        if (udp_reg)
                        begin
                            if (inb && dip_reg != 32'd0 && !lookup_ok)
                                v_reg <= V_DROP;
                            else if (!inb && !res_reg.hit)
                                v_reg <= V_DROP;
                            else if (do_upd)
                            begin
                                v_reg <= V_REWRITE;
                                si_reg <= sidx;
                                ne_reg <= miss_ins;
                                if (inb)
                                    od_reg <= srv_addr_reg[sidx];
                                else
                                    os_reg <= pub_addr_reg;
                            end
                        end
                        if (do_upd)
                        begin
                            clock_reg <= clock_reg + 1'b1;
                            if (miss_ins && count_reg < CNT_W'(TABLE_DEPTH))
                                count_reg <= count_reg + 1'b1;
                            for (int i = 0; i < SERVER_COUNT; i++)
                            begin
                                if (2'(i) == sidx)
                                begin
                                    if (miss_ins)
                                        load_reg[i] <= LOAD_W'(1);
                                    else if (load_reg[i] != '1)
                                        load_reg[i] <= load_reg[i] + 1'b1;
                                end
                                else if (miss_ins)
                                    load_reg[i] <= '0;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign verdict = v_reg;
    assign out_src_ip = os_reg;
    assign out_dst_ip = od_reg;
    assign server_index = si_reg;
    assign new_entry = ne_reg;

`ifndef NO_ASSERTIONS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH)) else $error("fill count overrun");
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict != 2'd3) else $error("bad verdict");
    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_entry |-> verdict == V_REWRITE) else $error("insert not rewritten");
`endif
endmodule
`default_nettype wire
